>>> hdl/lswc_pkg.sv
package lswc_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAX_MOVES  = 16;
    localparam int MOVE_BITS  = $clog2(MAX_MOVES + 1);

    // Interpolation widths: coordinate differences carry one extra bit,
    // and the exact product of two difference magnitudes twice that.
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;

    localparam logic [3:0] OC_LEFT  = 4'd1;
    localparam logic [3:0] OC_RIGHT = 4'd2;
    localparam logic [3:0] OC_BELOW = 4'd4;
    localparam logic [3:0] OC_ABOVE = 4'd8;
    localparam logic [3:0] OC_NONE  = 4'd0;

    localparam logic signed [COORD_BITS-1:0] WIN_MIN_X_RST = COORD_BITS'(0);
    localparam logic signed [COORD_BITS-1:0] WIN_MIN_Y_RST = COORD_BITS'(0);
    localparam logic signed [COORD_BITS-1:0] WIN_MAX_X_RST = COORD_BITS'(639);
    localparam logic signed [COORD_BITS-1:0] WIN_MAX_Y_RST = COORD_BITS'(479);

    typedef enum logic [1:0] {
        CFG_WIN_MIN_X = 2'd0,
        CFG_WIN_MIN_Y = 2'd1,
        CFG_WIN_MAX_X = 2'd2,
        CFG_WIN_MAX_Y = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } seg_t;

    typedef struct packed {
        logic                         visible;
        logic signed [COORD_BITS-1:0] clip_start_x;
        logic signed [COORD_BITS-1:0] clip_start_y;
        logic signed [COORD_BITS-1:0] clip_end_x;
        logic signed [COORD_BITS-1:0] clip_end_y;
    } clip_t;

    function automatic logic [3:0] outcode(
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y,
        input logic signed [COORD_BITS-1:0] min_x,
        input logic signed [COORD_BITS-1:0] min_y,
        input logic signed [COORD_BITS-1:0] max_x,
        input logic signed [COORD_BITS-1:0] max_y
    );
        logic [3:0] code;
        code = OC_NONE;
        if (x < min_x)
        begin
            code = code | OC_LEFT;
        end
        else if (x > max_x)
        begin
            code = code | OC_RIGHT;
        end
        if (y < min_y)
        begin
            code = code | OC_BELOW;
        end
        else if (y > max_y)
        begin
            code = code | OC_ABOVE;
        end
        return code;
    endfunction

endpackage

>>> hdl/lswc_div.sv
module lswc_div #(
    parameter int NUM_BITS = lswc_pkg::PROD_BITS,
    parameter int DEN_BITS = lswc_pkg::DIFF_BITS,
    parameter int Q_BITS   = lswc_pkg::COORD_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic                done,
    output logic [Q_BITS-1:0]   quotient
);
    import lswc_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   trial;
    logic                fits;

    // Restoring division: one quotient bit per cycle, shifted into the
    // bottom of the dividend register as the dividend bits leave the top.
    always_comb
    begin
        shifted = {rem_reg, num_reg[NUM_BITS-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = ~trial[DEN_BITS];

        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
            num_next = {num_reg[NUM_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg[Q_BITS-1:0];

endmodule

>>> hdl/line_segment_window_clipper.sv
// Cohen-Sutherland clipper for one 2D segment against the window held in the
// four configuration registers (edges inclusive, reset 0..639 by 0..479).
// The result is offered after the boundary moves have been made
// (0 to 4 for ordinary segments, never more than 16). Each move is
// spent mostly in a shared restoring divider that produces one
// quotient bit per cycle over the 34-bit exact product.
// A new segment is taken once the previous one has reached the output
// register. Rejected segments come out with visible low and all endpoint
// coordinates zero; visible segments keep the endpoint order left by the
// exchanges made during clipping.
module line_segment_window_clipper (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seg_valid,
    output logic                        seg_stall,
    input  lswc_pkg::seg_t              seg,
    output logic                        clip_valid,
    input  logic                        clip_stall,
    output lswc_pkg::clip_t             clip,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  lswc_pkg::cfg_idx_t          cfg_index,
    input  logic [lswc_pkg::COORD_BITS-1:0] cfg_data
);
    import lswc_pkg::*;

    localparam int W = COORD_BITS;
    localparam int D = DIFF_BITS;
    localparam int P = PROD_BITS;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_MAG   = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [W-1:0] win_min_x_reg, win_min_y_reg, win_max_x_reg, win_max_y_reg;

    logic signed [W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [W-1:0] edge_reg, edge_next;
    logic                xedge_reg, xedge_next;
    logic [MOVE_BITS-1:0] moves_reg, moves_next;
    logic                vis_reg, vis_next;

    logic signed [D-1:0] d0_reg, d0_next, dn_reg, dn_next, dd_reg, dd_next;
    logic [D-1:0]        mag_d0_reg, mag_d0_next, mag_dn_reg, mag_dn_next;
    logic [D-1:0]        mag_dd_reg, mag_dd_next;
    logic                neg_reg, neg_next;
    logic                ddz_reg, ddz_next;

    clip_t               clip_reg, clip_next;
    logic                clip_valid_reg, clip_valid_next;

    logic [3:0]          ca, cb, code;
    logic                swap;
    logic signed [W-1:0] a0, b0, a1, b1;
    logic                out_free;
    logic [P-1:0]        prod;
    logic                div_start;
    logic                div_done;
    logic [W-1:0]        div_q;
    logic [W-1:0]        q_eff;
    logic [W-1:0]        moved;

    lswc_div #(
        .NUM_BITS (P),
        .DEN_BITS (D),
        .Q_BITS   (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (mag_dd_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_min_x_reg <= WIN_MIN_X_RST;
            win_min_y_reg <= WIN_MIN_Y_RST;
            win_max_x_reg <= WIN_MAX_X_RST;
            win_max_y_reg <= WIN_MAX_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIN_MIN_X: win_min_x_reg <= cfg_data;
                CFG_WIN_MIN_Y: win_min_y_reg <= cfg_data;
                CFG_WIN_MAX_X: win_max_x_reg <= cfg_data;
                CFG_WIN_MAX_Y: win_max_y_reg <= cfg_data;
                default:       win_min_x_reg <= win_min_x_reg;
            endcase
        end
    end

    assign ca = outcode(ax_reg, ay_reg, win_min_x_reg, win_min_y_reg,
                        win_max_x_reg, win_max_y_reg);
    assign cb = outcode(bx_reg, by_reg, win_min_x_reg, win_min_y_reg,
                        win_max_x_reg, win_max_y_reg);
    assign swap = (ca == OC_NONE);
    assign code = swap ? cb : ca;

    // An x boundary interpolates y along x, a y boundary the other way round.
    assign a0 = xedge_reg ? ay_reg : ax_reg;
    assign b0 = xedge_reg ? by_reg : bx_reg;
    assign a1 = xedge_reg ? ax_reg : ay_reg;
    assign b1 = xedge_reg ? bx_reg : by_reg;

    assign prod      = mag_d0_reg * mag_dn_reg;
    assign div_start = (state_reg == ST_MUL);
    assign q_eff     = ddz_reg ? '0 : div_q;
    assign moved     = neg_reg ? (a0 - q_eff) : (a0 + q_eff);
    assign out_free  = !clip_valid_reg || !clip_stall;

    always_comb
    begin
        state_next      = state_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        edge_next       = edge_reg;
        xedge_next      = xedge_reg;
        moves_next      = moves_reg;
        vis_next        = vis_reg;
        d0_next         = d0_reg;
        dn_next         = dn_reg;
        dd_next         = dd_reg;
        mag_d0_next     = mag_d0_reg;
        mag_dn_next     = mag_dn_reg;
        mag_dd_next     = mag_dd_reg;
        neg_next        = neg_reg;
        ddz_next        = ddz_reg;
        clip_next       = clip_reg;
        clip_valid_next = clip_valid_reg && clip_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (seg_valid)
                begin
                    ax_next    = seg.start_x;
                    ay_next    = seg.start_y;
                    bx_next    = seg.end_x;
                    by_next    = seg.end_y;
                    moves_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if ((ca | cb) == OC_NONE)
                begin
                    vis_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (((ca & cb) != OC_NONE) || (moves_reg == MOVE_BITS'(MAX_MOVES)))
                begin
                    vis_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (swap)
                    begin
                        ax_next = bx_reg;
                        ay_next = by_reg;
                        bx_next = ax_reg;
                        by_next = ay_reg;
                    end
                    if ((code & OC_LEFT) != OC_NONE)
                    begin
                        xedge_next = 1'b1;
                        edge_next  = win_min_x_reg;
                    end
                    else if ((code & OC_RIGHT) != OC_NONE)
                    begin
                        xedge_next = 1'b1;
                        edge_next  = win_max_x_reg;
                    end
                    else if ((code & OC_BELOW) != OC_NONE)
                    begin
                        xedge_next = 1'b0;
                        edge_next  = win_min_y_reg;
                    end
                    else
                    begin
                        xedge_next = 1'b0;
                        edge_next  = win_max_y_reg;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                d0_next    = {b0[W-1], b0} - {a0[W-1], a0};
                dn_next    = {edge_reg[W-1], edge_reg} - {a1[W-1], a1};
                dd_next    = {b1[W-1], b1} - {a1[W-1], a1};
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                mag_d0_next = d0_reg[D-1] ? -d0_reg : d0_reg;
                mag_dn_next = dn_reg[D-1] ? -dn_reg : dn_reg;
                mag_dd_next = dd_reg[D-1] ? -dd_reg : dd_reg;
                neg_next    = d0_reg[D-1] ^ dn_reg[D-1] ^ dd_reg[D-1];
                ddz_next    = (dd_reg == '0);
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (xedge_reg)
                    begin
                        ax_next = edge_reg;
                        ay_next = moved;
                    end
                    else
                    begin
                        ax_next = moved;
                        ay_next = edge_reg;
                    end
                    moves_next = moves_reg + MOVE_BITS'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    clip_next.visible      = vis_reg;
                    clip_next.clip_start_x = vis_reg ? ax_reg : '0;
                    clip_next.clip_start_y = vis_reg ? ay_reg : '0;
                    clip_next.clip_end_x   = vis_reg ? bx_reg : '0;
                    clip_next.clip_end_y   = vis_reg ? by_reg : '0;
                    clip_valid_next        = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            moves_reg      <= '0;
            clip_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            moves_reg      <= moves_next;
            clip_valid_reg <= clip_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        edge_reg   <= edge_next;
        xedge_reg  <= xedge_next;
        vis_reg    <= vis_next;
        d0_reg     <= d0_next;
        dn_reg     <= dn_next;
        dd_reg     <= dd_next;
        mag_d0_reg <= mag_d0_next;
        mag_dn_reg <= mag_dn_next;
        mag_dd_reg <= mag_dd_next;
        neg_reg    <= neg_next;
        ddz_reg    <= ddz_next;
        clip_reg   <= clip_next;
    end

    assign seg_stall  = (state_reg != ST_IDLE);
    assign clip_valid = clip_valid_reg;
    assign clip       = clip_reg;

`ifndef SYNTH
    a_moves_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        moves_reg <= MOVE_BITS'(MAX_MOVES))
        else $error("boundary move count exceeded its bound");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && !clip.visible |-> clip.clip_start_x == '0 &&
        clip.clip_start_y == '0 && clip.clip_end_x == '0 && clip.clip_end_y == '0)
        else $error("rejected segment carries nonzero coordinates");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_stall |=> state_reg == ST_CHECK)
        else $error("accepted segment did not start its outcode check");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide wait");
`endif

endmodule
